// ----- sv/dfso_pkg.sv -----
// Shared widths, operation codes and the lowest-set-bit encoder for the depth-first search block.
`default_nettype none
package dfso_pkg;

   localparam int ROW_W = 16;   // adjacency row width, one bit per vertex
   localparam int VTX_W = 4;    // vertex number width
   localparam int CNT_W = 5;    // vertex count register width

   localparam logic [CNT_W-1:0] COUNT_RESET = 5'd16;

   localparam logic OP_ROW_WRITE = 1'b0;
   localparam logic OP_SEARCH    = 1'b1;

   typedef logic [ROW_W-1:0] row_type;
   typedef logic [VTX_W-1:0] vertex_type;

   // Return the index of the lowest set bit; zero when no bit is set.
   function automatic vertex_type lowest_set(input row_type bits);
      vertex_type idx;
      idx = '0;
      for (int i = ROW_W - 1; i >= 0; i--) begin
         if (bits[i]) begin
            idx = VTX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage
`default_nettype wire

// ----- sv/dfso_ram.sv -----
// Simple dual-port synchronous RAM with registered read.
`default_nettype none
module dfso_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- sv/depth_first_search_order.sv -----
// Top level: iterative depth-first search over an adjacency matrix held in RAM.
//
//   channel   ports                                   transfer when
//   request   start, busy, req_*                      start high and busy low
//   response  rsp_valid, rsp_vertex, rsp_last         rsp_valid high (one cycle each)
//   config    csr_wr_en, csr_wr_data                  csr_wr_en high
//
// A row write returns nothing; busy stays low.
// A search loads the start vertex, emits one vertex per visit in ST_EXPAND, pops
// the stack through ST_POP back to ST_EXPAND and closes in ST_DONE; its pace is set
// by the registered reads of the adjacency and stack RAMs in the expand/pop loop.
// Reset clears the control state and loads vertex_count with 16; RAM contents are
// not cleared. The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module depth_first_search_order
   import dfso_pkg::*;
#(
   parameter int MAX_VERTICES = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output      logic             busy,
   input  wire logic             req_operation,
   input  wire logic [3:0]       req_row_index,
   input  wire logic [15:0]      req_row_bits,
   input  wire logic [3:0]       req_start_vertex,
   output      logic             rsp_valid,
   output      logic [3:0]       rsp_vertex,
   output      logic             rsp_last,
   input  wire logic             csr_wr_en,
   input  wire logic [CNT_W-1:0] csr_wr_data
);

   // Vertices beyond the row width never have edges, so storage stops there.
   localparam int ADJ_DEPTH = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;
   localparam int AW        = $clog2(ADJ_DEPTH);
   localparam logic [6:0] MAX_N = 7'(MAX_VERTICES);
   localparam logic [CNT_W-1:0] ADJ_ROWS = CNT_W'(ADJ_DEPTH);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXPAND = 2'd1;  // adjacency row of top vertex is on RAM output
   localparam logic [1:0] ST_POP    = 2'd2;  // popped vertex is on stack RAM output
   localparam logic [1:0] ST_DONE   = 2'd3;  // emit the held vertex as the final one

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff;
   row_type          visited_ff, visited_in;
   row_type          mask_ff, mask_in;
   vertex_type       top_ff, top_in;
   logic [AW-1:0]    depth_ff, depth_in;
   vertex_type       pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   vertex_type       rsp_vertex_ff, rsp_vertex_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             accept;
   logic [6:0]       eff_count;
   row_type          use_mask;
   logic             start_ok;

   logic             adj_we;
   logic             adj_re;
   logic [AW-1:0]    adj_raddr;
   row_type          adj_rd;

   logic             stk_we;
   logic             stk_re;
   logic [AW-1:0]    stk_raddr;
   vertex_type       stk_rd;

   row_type          cand;
   logic             has_open;
   vertex_type       next_v;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // Effective vertex count: zero counts as one, clamp to the configured maximum.
   always_comb begin
      priority if (count_ff == '0) begin
         eff_count = 7'd1;
      end else if (7'(count_ff) > MAX_N) begin
         eff_count = MAX_N;
      end else begin
         eff_count = 7'(count_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < ROW_W; i++) begin
         use_mask[i] = (7'(i) < eff_count);
      end
   end

   assign start_ok = (7'(req_start_vertex) < eff_count);

   // Row writes go straight into the adjacency RAM; rows past the storage drop.
   assign adj_we = accept && (req_operation == OP_ROW_WRITE)
                   && ({1'b0, req_row_index} < ADJ_ROWS);

   dfso_ram #(
      .DEPTH (ADJ_DEPTH),
      .WIDTH (ROW_W)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_we),
      .wr_addr (req_row_index[AW-1:0]),
      .wr_data (req_row_bits),
      .rd_en   (adj_re),
      .rd_addr (adj_raddr),
      .rd_data (adj_rd)
   );

   // Stack below the top vertex; the top itself lives in top_ff. A push and a
   // pop never fall in the same cycle, so no forwarding is needed.
   dfso_ram #(
      .DEPTH (ADJ_DEPTH),
      .WIDTH (VTX_W)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (depth_ff),
      .wr_data (top_ff),
      .rd_en   (stk_re),
      .rd_addr (stk_raddr),
      .rd_data (stk_rd)
   );

   // Open neighbors of the top vertex: edges to in-use, unvisited vertices.
   assign cand     = adj_rd & ~visited_ff & mask_ff;
   assign has_open = |cand;
   assign next_v   = lowest_set(cand);
   assign stk_raddr = depth_ff - 1'b1;

   always_comb begin
      state_in      = state_ff;
      visited_in    = visited_ff;
      mask_in       = mask_ff;
      top_in        = top_ff;
      depth_in      = depth_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_last_in   = rsp_last_ff;
      adj_re        = 1'b0;
      adj_raddr     = top_ff[AW-1:0];
      stk_we        = 1'b0;
      stk_re        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_operation == OP_SEARCH)) begin
               // Hold the start vertex; it goes out once we know whether it is last.
               pend_in    = req_start_vertex;
               top_in     = req_start_vertex;
               visited_in = row_type'(1) << req_start_vertex;
               mask_in    = use_mask;
               depth_in   = '0;
               adj_re     = 1'b1;
               adj_raddr  = req_start_vertex[AW-1:0];
               state_in   = start_ok ? ST_EXPAND : ST_DONE;
            end
         end
         ST_EXPAND: begin
            if (has_open) begin
               // Visit: release the held vertex, push the old top, descend.
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = pend_ff;
               rsp_last_in   = 1'b0;
               pend_in       = next_v;
               visited_in    = visited_ff | (row_type'(1) << next_v);
               stk_we        = 1'b1;
               depth_in      = depth_ff + 1'b1;
               top_in        = next_v;
               adj_re        = 1'b1;
               adj_raddr     = next_v[AW-1:0];
            end else if (depth_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               // Exhausted: pop the vertex below.
               stk_re   = 1'b1;
               depth_in = depth_ff - 1'b1;
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            top_in    = stk_rd;
            adj_re    = 1'b1;
            adj_raddr = stk_rd[AW-1:0];
            state_in  = ST_EXPAND;
         end
         ST_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_vertex_in = pend_ff;
            rsp_last_in   = 1'b1;
            state_in      = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= COUNT_RESET;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      visited_ff    <= visited_in;
      mask_ff       <= mask_in;
      top_ff        <= top_in;
      pend_ff       <= pend_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_vertex = rsp_vertex_ff;
   assign rsp_last   = rsp_last_ff;

endmodule
`default_nettype wire
